@@ hw/rtl/pdof_pkg.sv @@
package pdof_pkg;

	// bin count handled by the probe; indexes at or above it are out of range
	localparam int NUM_BINS = 64;

	// fixed field widths
	localparam int BIN_W = 6;
	localparam int RAD_W = 20;
	localparam int SPD_W = 16;
	localparam int DOF_W = 24;
	localparam int CFG_W = 16;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RESOLUTION = 2'd0,
		REG_RESPONSE   = 2'd1,
		REG_FIRST_BIN  = 2'd2,
		REG_LAST_BIN   = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [9:0]  RESOLUTION_RST = 10'd25;
	localparam logic [15:0] RESPONSE_RST   = 16'd410;
	localparam logic [5:0]  FIRST_BIN_RST  = 6'd1;
	localparam logic [6:0]  LAST_BIN_RST   = 7'd64;

	// pipeline geometry
	localparam int X_BITS       = 34;  // quotient bits of time / time constant (Q30, < 16)
	localparam int HORNER_TERMS = 12;  // exp(-r) series terms
	localparam int EXP_STEPS    = 15;  // repeated exp(-1) factors, integer part < 16
	localparam int F_BITS       = 23;  // quotient bits of 70 / fraction (Q16)
	localparam int LATENCY      = 120;

	// constants
	localparam logic [28:0] EXPM1_Q30  = 29'd395007542;  // exp(-1) in Q30
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [24:0] Z_RECIP    = 25'd17592186;   // floor(2^38 / 15625)
	localparam logic [37:0] Z_DIV      = 38'd15625;
	localparam logic [19:0] LIN_COEF   = 20'd628000;
	localparam logic [11:0] QUAD_COEF  = 12'd3246;
	localparam logic [14:0] DOF_COEF   = 15'd25280;

	// sideband carried with an item down the pipeline
	typedef struct packed {
		logic        inr;
		logic [24:0] r2;
	} side_t;

	// carried through the exponential stages
	typedef struct packed {
		side_t       side;
		logic        big;
		logic [3:0]  n;
		logic [29:0] r;
	} hcar_t;

	// carried through the tail stages
	typedef struct packed {
		logic        inr;
		logic        occ;
		logic [24:0] r2;
	} tail_t;

endpackage

@@ hw/rtl/probe_depth_of_field_top.sv @@
// Depth of field of one size bin of an optical array particle probe.
//
// Input: an item (bin_index, bin_radius, airspeed) is taken at a rising edge
// with start high and busy low. busy stays low: one item may enter every cycle.
// Output: one result item per input item, in order. done is high for exactly
// one cycle with depth_field, in_range and occulted; the receiver must take it.
// The result is taken at the rising edge that ends the cycle in which done is high.
// Throughput: one item per cycle, set by the fully pipelined datapath: an
// input stage, a setup stage and a 34-stage radix-2 divider for the transit
// ratio, 36 stages of series evaluation for exp, 15 stages of exp(-1) factors,
// one fraction stage, a 23-stage divider for 70/fraction, and nine stages of
// polynomial, scaling and rounding.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers are read live by the pipeline, so write them only
// while no item is in flight.
// Reset: arst_n low clears all valid bits and loads register defaults; items
// in flight are dropped.
module probe_depth_of_field_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  bin_index,
	input  logic [19:0] bin_radius,
	input  logic [15:0] airspeed,
	output logic        done,
	output logic [23:0] depth_field,
	output logic        in_range,
	output logic        occulted,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LAT = pdof_pkg::LATENCY;
	localparam int XB  = pdof_pkg::X_BITS;
	localparam int HT  = pdof_pkg::HORNER_TERMS;
	localparam int ES  = pdof_pkg::EXP_STEPS;
	localparam int FB  = pdof_pkg::F_BITS;

	// configuration registers
	logic [9:0]  res_q;
	logic [15:0] rt_q;
	logic [5:0]  fb_q;
	logic [6:0]  lb_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= pdof_pkg::RESOLUTION_RST;
			rt_q  <= pdof_pkg::RESPONSE_RST;
			fb_q  <= pdof_pkg::FIRST_BIN_RST;
			lb_q  <= pdof_pkg::LAST_BIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (pdof_pkg::cfg_reg_t'(cfg_index))
				pdof_pkg::REG_RESOLUTION: res_q <= cfg_data[9:0];
				pdof_pkg::REG_RESPONSE:   rt_q  <= cfg_data;
				pdof_pkg::REG_FIRST_BIN:  fb_q  <= cfg_data[5:0];
				pdof_pkg::REG_LAST_BIN:   lb_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// valid bits: one per stage, shift with the data
	logic [LAT-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_s[LAT-1];

	// stage 1: range check, size, denominator, radius squared
	logic        inr_s1;
	logic [28:0] size_s1;
	logic [31:0] den_s1;
	logic [39:0] sq_s1;

	always_ff @(posedge clk) begin
		inr_s1  <= (bin_index >= fb_q) && ({1'b0, bin_index} < lb_q)
			&& (9'(bin_index) < 9'(pdof_pkg::NUM_BINS));
		size_s1 <= 29'(28'(bin_radius) * 28'd250) + 29'({res_q, 12'd0});
		den_s1  <= 32'(airspeed) * 32'(rt_q);
		sq_s1   <= 40'(bin_radius) * 40'(bin_radius);
	end

	// transit ratio divider: element 0 is setup, one quotient bit per stage
	logic [31:0]       xrem_s  [0:XB];
	logic [31:0]       xden_s  [0:XB];
	logic [XB-1:0]     xq_s    [0:XB];
	logic              xbig_s  [0:XB];
	pdof_pkg::side_t   xside_s [0:XB];

	always_ff @(posedge clk) begin
		xrem_s[0]  <= 32'(size_s1);
		xden_s[0]  <= den_s1;
		xq_s[0]    <= '0;
		// ratio of 16 or more, or zero denominator: fraction is one
		xbig_s[0]  <= {3'b000, size_s1} >= den_s1;
		xside_s[0] <= '{inr: inr_s1, r2: 25'((sq_s1 + 40'd32768) >> 16)};
	end

	for (genvar j = 0; j < XB; j++) begin : g_xdiv
		logic [32:0] sh;
		logic        ge;

		always_comb begin
			sh = {xrem_s[j], 1'b0};
			ge = sh >= {1'b0, xden_s[j]};
		end

		always_ff @(posedge clk) begin
			xrem_s[j+1]  <= ge ? 32'(sh - {1'b0, xden_s[j]}) : sh[31:0];
			xden_s[j+1]  <= xden_s[j];
			xq_s[j+1]    <= {xq_s[j][XB-2:0], ge};
			xbig_s[j+1]  <= xbig_s[j];
			xside_s[j+1] <= xside_s[j];
		end
	end

	// exp(-r) by Horner: three stages per term (product, reciprocal, fix-up)
	pdof_pkg::hcar_t hca_s [0:HT-1];
	pdof_pkg::hcar_t hcb_s [0:HT-1];
	pdof_pkg::hcar_t hcc_s [0:HT-1];
	logic [29:0]     hva_s [0:HT-1];
	logic [29:0]     hvb_s [0:HT-1];
	logic [29:0]     hqb_s [0:HT-1];
	logic [30:0]     hpc_s [0:HT-1];

	for (genvar i = 0; i < HT; i++) begin : g_horner
		localparam int K = HT - i;
		localparam logic [32:0] M = 33'((64'd1 << 32) / K);
		pdof_pkg::hcar_t cin;
		logic [30:0]     pin;
		logic [60:0]     rp;
		logic [62:0]     vm;
		logic [33:0]     qk;
		logic [33:0]     rem;
		logic [29:0]     t;

		if (i == 0) begin : g_first
			assign cin = '{side: xside_s[XB], big: xbig_s[XB],
				n: xq_s[XB][33:30], r: xq_s[XB][29:0]};
			assign pin = pdof_pkg::ONE_Q30;
		end else begin : g_next
			assign cin = hcc_s[i-1];
			assign pin = hpc_s[i-1];
		end

		assign rp  = 61'(cin.r) * 61'(pin);
		assign vm  = 63'(hva_s[i]) * 63'(M);
		assign qk  = 34'(hqb_s[i]) * 34'(K);
		assign rem = 34'(hvb_s[i]) - qk;
		// estimate is low by at most one
		assign t   = hqb_s[i] + 30'(rem >= 34'(K));

		always_ff @(posedge clk) begin
			hca_s[i] <= cin;
			hva_s[i] <= rp[59:30];
			hcb_s[i] <= hca_s[i];
			hvb_s[i] <= hva_s[i];
			hqb_s[i] <= vm[61:32];
			hcc_s[i] <= hcb_s[i];
			hpc_s[i] <= pdof_pkg::ONE_Q30 - 31'(t);
		end
	end

	// integer part: up to 15 exp(-1) factors, one stage each
	pdof_pkg::hcar_t ec_s [0:ES-1];
	logic [30:0]     ep_s [0:ES-1];

	for (genvar e = 0; e < ES; e++) begin : g_exp
		pdof_pkg::hcar_t cin;
		logic [30:0]     pin;
		logic [59:0]     pm;

		if (e == 0) begin : g_first
			assign cin = hcc_s[HT-1];
			assign pin = hpc_s[HT-1];
		end else begin : g_next
			assign cin = ec_s[e-1];
			assign pin = ep_s[e-1];
		end

		assign pm = 60'(pin) * 60'(pdof_pkg::EXPM1_Q30);

		always_ff @(posedge clk) begin
			ec_s[e] <= cin;
			ep_s[e] <= (cin.n > 4'(e)) ? 31'(pm >> 30) : pin;
		end
	end

	// response fraction and occultation test
	logic [16:0]     e16;
	logic [16:0]     frac;
	logic [16:0]     frac_s88;
	pdof_pkg::tail_t tl_s88;

	always_comb begin
		e16  = 17'((32'(ep_s[ES-1]) + 32'd8192) >> 14);
		frac = ec_s[ES-1].big ? 17'd65536 : 17'd65536 - e16;
	end

	always_ff @(posedge clk) begin
		frac_s88 <= frac;
		tl_s88   <= '{inr: ec_s[ES-1].side.inr,
			occ: (21'(frac) * 21'd10) >= 21'd458752,
			r2: ec_s[ES-1].side.r2};
	end

	// f = 70 / fraction, one quotient bit per stage
	logic [38:0]     nf;
	logic [16:0]     frem_s [0:FB-1];
	logic [FB-1:0]   fnum_s [0:FB-1];
	logic [FB-1:0]   fq_s   [0:FB-1];
	logic [16:0]     fdv_s  [0:FB-1];
	pdof_pkg::tail_t ftl_s  [0:FB-1];

	assign nf = (39'd70 << 32) + 39'(frac_s88 >> 1);

	for (genvar j = 0; j < FB; j++) begin : g_fdiv
		logic [16:0]     rin;
		logic [FB-1:0]   nin;
		logic [FB-1:0]   qin;
		logic [16:0]     dv;
		pdof_pkg::tail_t tin;
		logic [17:0]     sh;
		logic            ge;

		if (j == 0) begin : g_first
			assign rin = 17'(nf[38:FB]);
			assign nin = nf[FB-1:0];
			assign qin = '0;
			assign dv  = frac_s88;
			assign tin = tl_s88;
		end else begin : g_next
			assign rin = frem_s[j-1];
			assign nin = fnum_s[j-1];
			assign qin = fq_s[j-1];
			assign dv  = fdv_s[j-1];
			assign tin = ftl_s[j-1];
		end

		assign sh = {rin, nin[FB-1]};
		assign ge = sh >= {1'b0, dv};

		always_ff @(posedge clk) begin
			frem_s[j] <= ge ? 17'(sh - {1'b0, dv}) : sh[16:0];
			fnum_s[j] <= {nin[FB-2:0], 1'b0};
			fq_s[j]   <= {qin[FB-2:0], ge};
			fdv_s[j]  <= dv;
			ftl_s[j]  <= tin;
		end
	end

	// polynomial z = 30.46 - 0.628 f + 0.003246 f^2
	logic [45:0]         fsq_s112;
	logic [42:0]         lin_s112;
	logic [57:0]         quad_s113;
	logic [42:0]         lin_s113;
	logic signed [60:0]  n_s114;
	pdof_pkg::tail_t     tl_s112, tl_s113, tl_s114;

	always_ff @(posedge clk) begin
		fsq_s112  <= 46'(fq_s[FB-1]) * 46'(fq_s[FB-1]);
		lin_s112  <= 43'(fq_s[FB-1]) * 43'(pdof_pkg::LIN_COEF);
		tl_s112   <= ftl_s[FB-1];
		quad_s113 <= 58'(fsq_s112) * 58'(pdof_pkg::QUAD_COEF);
		lin_s113  <= lin_s112;
		tl_s113   <= tl_s112;
		n_s114    <= $signed((61'd30460000 << 32) - (61'(lin_s113) << 16)
			+ 61'(quad_s113));
		tl_s114   <= tl_s113;
	end

	// z rounding divide by 4096000000 = 2^18 * 15625
	logic [60:0]     nsum;
	logic [36:0]     y_s115, y_s116;
	logic            pos_s115, pos_s116;
	logic [61:0]     ym;
	logic [23:0]     qe_s116;
	logic [37:0]     zrem;
	logic [23:0]     z_s117;
	pdof_pkg::tail_t tl_s115, tl_s116, tl_s117;

	assign nsum = 61'(n_s114) + 61'd2048000000;
	assign ym   = 62'(y_s115) * 62'(pdof_pkg::Z_RECIP);
	assign zrem = 38'(y_s116) - 38'(qe_s116) * pdof_pkg::Z_DIV;

	always_ff @(posedge clk) begin
		y_s115   <= nsum[54:18];
		pos_s115 <= n_s114 > 61'sd0;
		tl_s115  <= tl_s114;
		y_s116   <= y_s115;
		qe_s116  <= ym[61:38];
		pos_s116 <= pos_s115;
		tl_s116  <= tl_s115;
		z_s117   <= pos_s116 ? qe_s116 + 24'(zrem >= pdof_pkg::Z_DIV) : '0;
		tl_s117  <= tl_s116;
	end

	// dof = 25280 * z * r2 / 2^36, rounded and saturated
	logic [48:0]     zr_s118;
	logic [63:0]     prod_s119;
	logic [64:0]     psum;
	pdof_pkg::tail_t tl_s118, tl_s119;

	assign psum = 65'(prod_s119) + (65'd1 << 35);

	always_ff @(posedge clk) begin
		zr_s118   <= 49'(z_s117) * 49'(tl_s117.r2);
		tl_s118   <= tl_s117;
		prod_s119 <= 64'(zr_s118) * 64'(pdof_pkg::DOF_COEF);
		tl_s119   <= tl_s118;
	end

	// output register
	always_ff @(posedge clk) begin
		if (!(tl_s119.inr && tl_s119.occ)) begin
			depth_field <= '0;
		end else if (psum[64:36] > 29'hFF_FFFF) begin
			depth_field <= 24'hFF_FFFF;
		end else begin
			depth_field <= psum[59:36];
		end
		in_range <= tl_s119.inr;
		occulted <= tl_s119.inr & tl_s119.occ;
	end

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(pdof_pkg::LATENCY) done)
		else $error("item taken but no result after pipeline latency");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> depth_field == '0 && !occulted)
		else $error("out-of-range bin gave a nonzero result");

	a_not_occulted: assert property (@(posedge clk) disable iff (!arst_n)
		done && !occulted |-> depth_field == '0)
		else $error("depth of field set without occultation");

endmodule
